// ----- rtl/ikr_pkg.sv -----
// ikr_pkg: shared types and the key decode table for the keypad reader
// used by ikr_seq and i2c_keypad_reader_core; no dependencies
`default_nettype none

package ikr_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_DEV_ADDR  = 2'd0;
  localparam logic [1:0] CFG_UNIT_TCKS = 2'd1;
  localparam logic [1:0] CFG_ACK_TCKS  = 2'd2;

  localparam int CfgAddrW = 2;
  localparam int CfgDataW = 16;

  // register reset values
  localparam logic [6:0]  DEV_ADDR_RST  = 7'd0;
  localparam logic [15:0] UNIT_TCKS_RST = 16'd1000;
  localparam logic [7:0]  ACK_TCKS_RST  = 8'd250;

  // word reported after an address nack, and the no-key code
  localparam logic [15:0] NACK_WORD = 16'h00FF;
  localparam logic [7:0]  KEY_NONE  = 8'hFF;

  typedef struct packed {
    logic [6:0]  dev_addr;
    logic [15:0] unit_ticks;
    logic [7:0]  ack_ticks;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  key_code;
    logic [15:0] read_word;
    logic        address_nack;
    logic        done_res;
    logic        busy_res;
    logic        sda_level;
    logic        sda_drive_enable;
    logic        scl_level;
  } result_t;

  // one-hot keypad word to key code
  function automatic logic [7:0] key_decode(input logic [15:0] w);
    logic [7:0] k;
    unique case (w)
      16'h8000: k = 8'd0;
      16'h4000: k = 8'd1;
      16'h2000: k = 8'd2;
      16'h1000: k = 8'd3;
      16'h0100: k = 8'd4;
      16'h0400: k = 8'd5;
      16'h0200: k = 8'd6;
      16'h0800: k = 8'd7;
      16'h0040: k = 8'd8;
      16'h0020: k = 8'd9;
      16'h0010: k = 8'd35;
      16'h0080: k = 8'd77;
      default:  k = KEY_NONE;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/i2c_keypad_reader_core.sv -----
// i2c_keypad_reader_core: top level of the tick-driven i2c keypad reader
// depends on ikr_pkg and ikr_seq
//
// channel  dir  width  contents
// in_*     in   8      one tick: start_read, sda_in
// out_*    out  32     line levels, status, read word and key code for that tick
// cfg_*    in   16     register writes: address, delay unit, ack window
//
// one tick is taken per clock while out_tready allows; every tick gives exactly one result
// a tick is held in the input register, then the sequencer step and
// the result register load in the same cycle
// out_tready low holds the result register and, through it, the input register
// reset: synchronous on rst_n low; sequencer idle, lines released, word cleared
`default_nettype none

module i2c_keypad_reader_core
  import ikr_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  // input ticks
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire logic [7:0]          in_tdata,   // [0] start_read, [1] sda_in, rest zero
  // results
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  output logic [31:0]              out_tdata,  // [0] scl_level, [1] sda_drive_enable,
                                               // [2] sda_level, [3] busy_res, [4] done_res,
                                               // [5] address_nack, [21:6] read_word,
                                               // [29:22] key_code, rest zero
  // configuration writes
  input  wire logic                cfg_we,
  input  wire logic [CfgAddrW-1:0] cfg_addr,
  input  wire logic [CfgDataW-1:0] cfg_wdata
);

  cfg_t    cfg_r;
  logic    s1_valid_r;
  logic    s1_start_r, s1_sda_r;
  logic    out_valid_r;
  result_t out_r;
  result_t res;
  logic    adv;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dev_addr   <= DEV_ADDR_RST;
      cfg_r.unit_ticks <= UNIT_TCKS_RST;
      cfg_r.ack_ticks  <= ACK_TCKS_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_DEV_ADDR:  cfg_r.dev_addr   <= cfg_wdata[6:0];
        CFG_UNIT_TCKS: cfg_r.unit_ticks <= cfg_wdata;
        CFG_ACK_TCKS:  cfg_r.ack_ticks  <= cfg_wdata[7:0];
        default:       cfg_r            <= cfg_r;
      endcase
    end
  end

  // handshake: stage one moves on when the result register is free
  assign adv       = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || adv;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_start_r <= in_tdata[0];
      s1_sda_r   <= in_tdata[1];
    end
  end

  // sequencer
  ikr_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (adv),
    .start_read (s1_start_r),
    .sda_in     (s1_sda_r),
    .cfg        (cfg_r),
    .res        (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) out_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_r};

endmodule

`default_nettype wire

// ----- rtl/ikr_seq.sv -----
// ikr_seq: i2c pin sequencer state and its one-tick next-state logic
// depends on ikr_pkg
`default_nettype none

module ikr_seq
  import ikr_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    step,
  input  wire logic    start_read,
  input  wire logic    sda_in,
  input  wire cfg_t    cfg,
  output result_t      res
);

  typedef enum logic [3:0] {
    PH_IDLE, PH_ST_A, PH_ST_B, PH_ST_C, PH_TX_LO, PH_TX_HI,
    PH_AK_PREP, PH_AK_SET, PH_AK_POLL, PH_RX_LO, PH_RX_HI,
    PH_RS_LO, PH_RS_HI, PH_SP_LO, PH_SP_HI, PH_FIN
  } phase_t;

  // line codes: scl, sda drive enable, sda level
  localparam logic [2:0] LN_IDLE = 3'b101;
  localparam logic [2:0] LN_HH   = 3'b111;
  localparam logic [2:0] LN_HL   = 3'b110;
  localparam logic [2:0] LN_LL   = 3'b010;
  localparam logic [2:0] LN_LREL = 3'b001;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  bit_r, bit_nxt;
  logic [18:0] dly_r, dly_nxt;
  logic [7:0]  ackw_r, ackw_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [7:0]  first_r, first_nxt;
  logic [15:0] word_r, word_nxt;
  logic        bidx_r, bidx_nxt;
  logic        nack_r, nack_nxt;

  logic [15:0] unit;
  logic [7:0]  ack_eff;
  logic [2:0]  line;
  logic        busy, done, nack_out;
  logic        ent;
  phase_t      ent_ph;

  // zero counts behave as one
  assign unit    = (cfg.unit_ticks == '0) ? 16'd1 : cfg.unit_ticks;
  assign ack_eff = (cfg.ack_ticks == '0) ? 8'd1 : cfg.ack_ticks;

  // line levels for the current phase
  function automatic logic [2:0] lines(input phase_t p, input logic txb, input logic rsb);
    logic [2:0] l;
    unique case (p)
      PH_ST_A:    l = LN_HH;
      PH_ST_B:    l = LN_HL;
      PH_ST_C:    l = LN_LL;
      PH_TX_LO:   l = {2'b01, txb};
      PH_TX_HI:   l = {2'b11, txb};
      PH_AK_PREP: l = LN_LREL;
      PH_AK_SET:  l = LN_IDLE;
      PH_AK_POLL: l = LN_IDLE;
      PH_RX_LO:   l = LN_LREL;
      PH_RX_HI:   l = LN_IDLE;
      PH_RS_LO:   l = {2'b01, rsb};
      PH_RS_HI:   l = {2'b11, rsb};
      PH_SP_LO:   l = LN_LL;
      PH_SP_HI:   l = LN_HL;
      PH_FIN:     l = LN_HH;
      default:    l = LN_IDLE;
    endcase
    return l;
  endfunction

  // one tick of the sequencer
  always_comb begin
    phase_nxt = phase_r;
    bit_nxt   = bit_r;
    dly_nxt   = dly_r;
    ackw_nxt  = ackw_r;
    shift_nxt = shift_r;
    first_nxt = first_r;
    word_nxt  = word_r;
    bidx_nxt  = bidx_r;
    nack_nxt  = nack_r;
    busy      = 1'b0;
    done      = 1'b0;
    nack_out  = 1'b0;
    ent       = 1'b0;
    ent_ph    = PH_IDLE;
    line      = LN_IDLE;

    // request while idle runs the first start tick now
    if (phase_nxt == PH_IDLE && start_read) begin
      nack_nxt  = 1'b0;
      bidx_nxt  = 1'b0;
      bit_nxt   = '0;
      phase_nxt = PH_ST_A;
      dly_nxt   = {3'b000, unit};
    end

    if (phase_nxt == PH_IDLE) begin
      line = LN_IDLE;
    end else if (phase_nxt == PH_FIN) begin
      line      = LN_HH;
      done      = 1'b1;
      nack_out  = nack_nxt;
      phase_nxt = PH_IDLE;
    end else begin
      line = lines(phase_nxt, shift_nxt[7], bidx_nxt);
      busy = 1'b1;
      if (phase_nxt == PH_AK_POLL) begin
        // address ack window
        if (!sda_in) begin
          bit_nxt   = '0;
          shift_nxt = '0;
          bidx_nxt  = 1'b0;
          ent       = 1'b1;
          ent_ph    = PH_RX_LO;
        end else begin
          ackw_nxt = ackw_nxt - 8'd1;
          if (ackw_nxt == '0) begin
            nack_nxt = 1'b1;
            word_nxt = NACK_WORD;
            ent      = 1'b1;
            ent_ph   = PH_SP_LO;
          end
        end
      end else begin
        if (dly_nxt != '0) dly_nxt = dly_nxt - 19'd1;
        if (dly_nxt == '0) begin
          // end of phase
          unique case (phase_nxt)
            PH_ST_A: begin ent = 1'b1; ent_ph = PH_ST_B; end
            PH_ST_B: begin ent = 1'b1; ent_ph = PH_ST_C; end
            PH_ST_C: begin
              bit_nxt   = '0;
              shift_nxt = {cfg.dev_addr, 1'b1};
              ent       = 1'b1;
              ent_ph    = PH_TX_LO;
            end
            PH_TX_LO: begin ent = 1'b1; ent_ph = PH_TX_HI; end
            PH_TX_HI: begin
              shift_nxt = {shift_nxt[6:0], 1'b0};
              bit_nxt   = bit_nxt + 4'd1;
              ent       = 1'b1;
              ent_ph    = (bit_nxt >= 4'd8) ? PH_AK_PREP : PH_TX_LO;
            end
            PH_AK_PREP: begin ent = 1'b1; ent_ph = PH_AK_SET; end
            PH_AK_SET:  begin ent = 1'b1; ent_ph = PH_AK_POLL; end
            PH_RX_LO:   begin ent = 1'b1; ent_ph = PH_RX_HI; end
            PH_RX_HI: begin
              shift_nxt = {shift_nxt[6:0], sda_in};
              bit_nxt   = bit_nxt + 4'd1;
              ent       = 1'b1;
              if (bit_nxt >= 4'd8) begin
                if (!bidx_nxt) first_nxt = shift_nxt;
                else word_nxt = {first_nxt, shift_nxt};
                ent_ph = PH_RS_LO;
              end else begin
                ent_ph = PH_RX_LO;
              end
            end
            PH_RS_LO: begin ent = 1'b1; ent_ph = PH_RS_HI; end
            PH_RS_HI: begin
              ent = 1'b1;
              if (!bidx_nxt) begin
                bidx_nxt  = 1'b1;
                bit_nxt   = '0;
                shift_nxt = '0;
                ent_ph    = PH_RX_LO;
              end else begin
                ent_ph = PH_SP_LO;
              end
            end
            PH_SP_LO: begin ent = 1'b1; ent_ph = PH_SP_HI; end
            PH_SP_HI: begin
              phase_nxt = PH_FIN;
              dly_nxt   = '0;
            end
            default: phase_nxt = PH_IDLE;
          endcase
        end
      end
    end

    // load the count for the phase being entered
    if (ent) begin
      phase_nxt = ent_ph;
      if (ent_ph == PH_TX_LO)        dly_nxt = {2'b00, unit, 1'b0};
      else if (ent_ph == PH_AK_PREP) dly_nxt = {1'b0, unit, 2'b00} + {2'b00, unit, 1'b0};
      else                           dly_nxt = {3'b000, unit};
      if (ent_ph == PH_AK_POLL) ackw_nxt = ack_eff;
    end
  end

  // result of this tick
  always_comb begin
    res.scl_level        = line[2];
    res.sda_drive_enable = line[1];
    res.sda_level        = line[0];
    res.busy_res         = busy;
    res.done_res         = done;
    res.address_nack     = nack_out;
    res.read_word        = word_nxt;
    res.key_code         = key_decode(word_nxt);
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      bit_r   <= '0;
      dly_r   <= '0;
      ackw_r  <= '0;
      shift_r <= '0;
      first_r <= '0;
      word_r  <= '0;
      bidx_r  <= 1'b0;
      nack_r  <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      bit_r   <= bit_nxt;
      dly_r   <= dly_nxt;
      ackw_r  <= ackw_nxt;
      shift_r <= shift_nxt;
      first_r <= first_nxt;
      word_r  <= word_nxt;
      bidx_r  <= bidx_nxt;
      nack_r  <= nack_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- tb/i2c_keypad_reader_core_tb.sv -----
`timescale 1ns / 1ps
// i2c_keypad_reader_core_tb: self-checking bench for the tick-driven keypad reader
// emulates the keypad side from a tick-exact predictor; needs ikr_pkg and the core rtl

module i2c_keypad_reader_core_tb;
  import ikr_pkg::*;

  // sequencer phases as seen from the bus
  typedef enum logic [3:0] {
    P_IDLE, P_START_HI, P_START_LO, P_START_SCL, P_ADDR_LO, P_ADDR_HI,
    P_ACK_PREP, P_ACK_SET, P_ACK_POLL, P_RX_LO, P_RX_HI,
    P_RESP_LO, P_RESP_HI, P_STOP_LO, P_STOP_HI, P_DONE
  } seq_phase_t;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [7:0]          in_tdata;   // [0] start_read, [1] sda_in
  logic                out_tvalid;
  logic                out_tready;
  logic [31:0]         out_tdata;  // [0] scl, [1] sda drive, [2] sda level, [3] busy,
                                   // [4] done, [5] address nack, [21:6] word, [29:22] key
  logic                cfg_we;
  logic [CfgAddrW-1:0] cfg_addr;
  logic [CfgDataW-1:0] cfg_wdata;

  i2c_keypad_reader_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // predictor registers and sequencer state
  logic [6:0]  dev_addr_reg;
  logic [15:0] unit_reg;
  logic [7:0]  poll_reg;
  seq_phase_t  ph;
  int unsigned bit_n;
  int unsigned dly;
  logic [7:0]  win;
  logic [7:0]  shreg;
  logic [7:0]  hi_byte;
  logic [15:0] word;
  logic [2:0]  pins;
  logic        second;
  logic        nacked;

  // expected tick results, oldest first
  result_t tick_result_q[$];

  // keypad emulation plan for the current transfer
  logic [15:0] plan_word;
  logic        plan_ack;
  logic        plan_noise;
  int unsigned poll_wait;
  int unsigned ack_pct;
  int unsigned noise_pct;
  int unsigned start_pct;
  int unsigned busy_req_pct;

  // traffic shaping
  bit          in_gaps;
  bit          out_gaps;
  int unsigned stall_len;

  // bookkeeping
  int unsigned mismatches;
  int unsigned ticks_sent;
  int unsigned transfers_done;
  int unsigned nacks_seen;
  int unsigned keys_seen;
  int unsigned reg_writes;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #1_000_000;
    $display("[i2c_keypad_reader_core] ERROR");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [7:0] key_of_word(input logic [15:0] w);
    case (w)
      16'h8000: return 8'd0;
      16'h4000: return 8'd1;
      16'h2000: return 8'd2;
      16'h1000: return 8'd3;
      16'h0100: return 8'd4;
      16'h0400: return 8'd5;
      16'h0200: return 8'd6;
      16'h0800: return 8'd7;
      16'h0040: return 8'd8;
      16'h0020: return 8'd9;
      16'h0010: return 8'd35;
      16'h0080: return 8'd77;
      default:  return 8'hFF;
    endcase
  endfunction

  // scl, drive enable, sda level for a phase
  function automatic logic [2:0] pins_for(input seq_phase_t p);
    case (p)
      P_START_HI:  return 3'b111;
      P_START_LO:  return 3'b110;
      P_START_SCL: return 3'b010;
      P_ADDR_LO:   return {2'b01, shreg[7]};
      P_ADDR_HI:   return {2'b11, shreg[7]};
      P_ACK_PREP:  return 3'b001;
      P_ACK_SET:   return 3'b101;
      P_ACK_POLL:  return 3'b101;
      P_RX_LO:     return 3'b001;
      P_RX_HI:     return 3'b101;
      P_RESP_LO:   return {2'b01, second};
      P_RESP_HI:   return {2'b11, second};
      P_STOP_LO:   return 3'b010;
      P_STOP_HI:   return 3'b110;
      P_DONE:      return 3'b111;
      default:     return 3'b101;
    endcase
  endfunction

  // load the phase and its tick count; a zero register counts as one
  function automatic void enter_phase(input seq_phase_t p);
    int unsigned d_ticks;
    d_ticks = (unit_reg == 16'd0) ? 1 : unit_reg;
    ph = p;
    if (p == P_ADDR_LO) dly = 2 * d_ticks;
    else if (p == P_ACK_PREP) dly = 6 * d_ticks;
    else dly = d_ticks;
    if (p == P_ACK_POLL) win = (poll_reg == 8'd0) ? 8'd1 : poll_reg;
  endfunction

  function automatic void phase_advance(input logic sda);
    case (ph)
      P_START_HI:  enter_phase(P_START_LO);
      P_START_LO:  enter_phase(P_START_SCL);
      P_START_SCL: begin
        bit_n = 0;
        shreg = {dev_addr_reg, 1'b1};
        enter_phase(P_ADDR_LO);
      end
      P_ADDR_LO:   enter_phase(P_ADDR_HI);
      P_ADDR_HI: begin
        shreg = shreg << 1;
        bit_n++;
        if (bit_n >= 8) enter_phase(P_ACK_PREP);
        else enter_phase(P_ADDR_LO);
      end
      P_ACK_PREP:  enter_phase(P_ACK_SET);
      P_ACK_SET:   enter_phase(P_ACK_POLL);
      P_RX_LO:     enter_phase(P_RX_HI);
      P_RX_HI: begin
        shreg = {shreg[6:0], sda};
        bit_n++;
        if (bit_n >= 8) begin
          if (!second) hi_byte = shreg;
          else word = {hi_byte, shreg};
          enter_phase(P_RESP_LO);
        end else begin
          enter_phase(P_RX_LO);
        end
      end
      P_RESP_LO:   enter_phase(P_RESP_HI);
      P_RESP_HI: begin
        if (!second) begin
          second = 1'b1;
          bit_n = 0;
          shreg = 8'd0;
          enter_phase(P_RX_LO);
        end else begin
          enter_phase(P_STOP_LO);
        end
      end
      P_STOP_LO:   enter_phase(P_STOP_HI);
      P_STOP_HI: begin
        ph = P_DONE;
        dly = 0;
      end
      default:     ph = P_IDLE;
    endcase
  endfunction

  function automatic void model_reset();
    dev_addr_reg = DEV_ADDR_RST;
    unit_reg = UNIT_TCKS_RST;
    poll_reg = ACK_TCKS_RST;
    ph = P_IDLE;
    bit_n = 0;
    dly = 0;
    win = 8'd0;
    shreg = 8'd0;
    hi_byte = 8'd0;
    word = 16'd0;
    pins = 3'b101;
    second = 1'b0;
    nacked = 1'b0;
  endfunction

  // advance the predictor by one tick and give that tick's result
  function automatic result_t predict_tick(input logic start, input logic sda);
    result_t r;
    r = '0;
    if (ph == P_IDLE && start) begin
      nacked = 1'b0;
      second = 1'b0;
      bit_n = 0;
      enter_phase(P_START_HI);
    end
    if (ph == P_IDLE) begin
      pins = 3'b101;
    end else if (ph == P_DONE) begin
      pins = pins_for(P_DONE);
      r.done_res = 1'b1;
      r.address_nack = nacked;
      ph = P_IDLE;
    end else begin
      pins = pins_for(ph);
      r.busy_res = 1'b1;
      if (ph == P_ACK_POLL) begin
        // low sda is the ack; the window runs out into a stop
        if (!sda) begin
          bit_n = 0;
          shreg = 8'd0;
          second = 1'b0;
          enter_phase(P_RX_LO);
        end else begin
          win = win - 8'd1;
          if (win == 8'd0) begin
            nacked = 1'b1;
            word = 16'h00FF;
            enter_phase(P_STOP_LO);
          end
        end
      end else begin
        if (dly > 0) dly--;
        if (dly == 0) phase_advance(sda);
      end
    end
    r.scl_level = pins[2];
    r.sda_drive_enable = pins[1];
    r.sda_level = pins[0];
    r.read_word = word;
    r.key_code = key_of_word(word);
    return r;
  endfunction

  // ---------------------------------------------------------------- checking

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      mismatches++;
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
    end
  endfunction

  // compare every result transfer against the oldest expectation
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[29:0];
      if (tick_result_q.size() == 0) begin
        mismatches++;
        $error("result transfer with no tick pending");
      end else begin
        want = tick_result_q.pop_front();
        check_field("scl_level", want.scl_level, got.scl_level);
        check_field("sda_drive_enable", want.sda_drive_enable, got.sda_drive_enable);
        check_field("sda_level", want.sda_level, got.sda_level);
        check_field("busy_res", want.busy_res, got.busy_res);
        check_field("done_res", want.done_res, got.done_res);
        check_field("address_nack", want.address_nack, got.address_nack);
        check_field("read_word", want.read_word, got.read_word);
        check_field("key_code", want.key_code, got.key_code);
      end
    end
  end

  // result side ready, with random stalls and an occasional long hold-off
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_len != 0) begin
        out_tready <= 1'b0;
        repeat (stall_len - 1) @(negedge clk);
        stall_len = 0;
      end else begin
        out_tready <= !out_gaps || ($urandom_range(99) >= 36);
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  // one tick transfer; returns at the falling edge after acceptance
  task automatic send_tick(input logic start, input logic sda);
    result_t r;
    if (in_gaps && $urandom_range(99) < 36) begin
      in_tvalid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < 36);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'd0, sda, start};
    do @(posedge clk); while (!in_tready);
    r = predict_tick(start, sda);
    ticks_sent++;
    if (r.done_res) begin
      transfers_done++;
      if (r.address_nack) nacks_seen++;
      else if (r.key_code != KEY_NONE) keys_seen++;
    end
    tick_result_q.push_back(r);
    @(negedge clk);
  endtask

  // keypad side: answer the master according to the plan, noise elsewhere
  task automatic pick_tick(output logic start, output logic sda);
    int unsigned bit_idx;
    int unsigned eff_win;
    start = 1'b0;
    sda = 1'($urandom_range(1));
    case (ph)
      P_IDLE: begin
        if ($urandom_range(99) < start_pct) begin
          start = 1'b1;
          plan_noise = ($urandom_range(99) < noise_pct);
          plan_ack = ($urandom_range(99) < ack_pct);
          case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: plan_word = 16'h0001 << $urandom_range(15);
            6:                plan_word = NACK_WORD;
            default:          plan_word = 16'($urandom_range(16'hFFFF));
          endcase
          eff_win = (poll_reg == 8'd0) ? 1 : poll_reg;
          poll_wait = ($urandom_range(3) == 0) ? $urandom_range(eff_win - 1) : 0;
        end
      end
      P_ACK_POLL: begin
        if (!plan_noise) begin
          sda = !(plan_ack && poll_wait == 0);
          if (poll_wait != 0) poll_wait--;
        end
      end
      P_RX_HI: begin
        // only the last tick of the high half is sampled
        if (!plan_noise && dly == 1) begin
          bit_idx = (second ? 7 : 15) - bit_n;
          sda = plan_word[bit_idx];
        end
      end
      P_DONE:  start = (busy_req_pct == 100) ? 1'b1 : 1'($urandom_range(1));
      default: start = ($urandom_range(99) < busy_req_pct);
    endcase
  endtask

  task automatic drive_ticks(input int unsigned n);
    logic s;
    logic d;
    repeat (n) begin
      pick_tick(s, d);
      send_tick(s, d);
    end
  endtask

  task automatic drive_transfers(input int unsigned n);
    int unsigned target;
    logic s;
    logic d;
    target = transfers_done + n;
    while (transfers_done < target) begin
      pick_tick(s, d);
      send_tick(s, d);
    end
  endtask

  // finish whatever transfer is running, without starting another
  task automatic finish_transfer();
    logic s;
    logic d;
    start_pct = 0;
    while (ph != P_IDLE) begin
      pick_tick(s, d);
      send_tick(s, d);
    end
  endtask

  // stop offering ticks and wait for the pipeline to drain
  task automatic settle();
    in_tvalid <= 1'b0;
    while (tick_result_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgAddrW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_DEV_ADDR:  dev_addr_reg = val[6:0];
      CFG_UNIT_TCKS: unit_reg = val;
      CFG_ACK_TCKS:  poll_reg = val[7:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_traffic(input int unsigned ack, input int unsigned noise,
                             input int unsigned start, input int unsigned busy_req);
    ack_pct = ack;
    noise_pct = noise;
    start_pct = start;
    busy_req_pct = busy_req;
  endtask

  // ---------------------------------------------------------------- tests

  // before any transfer the word is zero and no key is decoded
  task automatic test_idle_after_reset();
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    settle();
  endtask

  // zero delay unit and zero ack window both act as one; top address
  task automatic test_zero_settings();
    write_reg(CFG_DEV_ADDR, 16'd127);
    write_reg(CFG_UNIT_TCKS, 16'd0);
    write_reg(CFG_ACK_TCKS, 16'd0);
    set_traffic(0, 0, 100, 0);
    drive_transfers(1);
    set_traffic(100, 0, 100, 0);
    drive_transfers(2);
    finish_transfer();
    settle();
  endtask

  // widest ack window running out, address zero, largest delay unit while idle
  task automatic test_extreme_settings();
    write_reg(CFG_DEV_ADDR, 16'd0);
    write_reg(CFG_UNIT_TCKS, 16'd1);
    write_reg(CFG_ACK_TCKS, 16'd255);
    set_traffic(0, 0, 100, 0);
    drive_transfers(1);
    set_traffic(100, 0, 100, 0);
    drive_transfers(1);
    finish_transfer();
    settle();
    write_reg(CFG_UNIT_TCKS, 16'hFFFF);
    write_reg(CFG_ACK_TCKS, 16'd1);
    set_traffic(100, 0, 0, 0);
    drive_ticks(6);
    settle();
    write_reg(CFG_UNIT_TCKS, 16'd1);
  endtask

  // requests during a transfer, the done tick included, are dropped
  task automatic test_requests_while_busy();
    write_reg(CFG_ACK_TCKS, 16'd3);
    set_traffic(100, 0, 100, 100);
    drive_transfers(2);
    set_traffic(0, 0, 100, 100);
    drive_transfers(1);
    finish_transfer();
    settle();
  endtask

  // registers rewritten while the sequencer sits in the middle of a transfer
  task automatic test_midstream_config();
    write_reg(CFG_UNIT_TCKS, 16'd3);
    write_reg(CFG_ACK_TCKS, 16'd6);
    set_traffic(100, 0, 100, 0);
    drive_ticks(40);
    settle();
    write_reg(CFG_DEV_ADDR, 16'($urandom_range(127)));
    write_reg(CFG_UNIT_TCKS, 16'd1);
    write_reg(CFG_ACK_TCKS, 16'd2);
    drive_transfers(1);
    drive_ticks(30);
    settle();
    write_reg(CFG_UNIT_TCKS, 16'd2);
    drive_transfers(1);
    settle();
  endtask

  // result side held off long enough for the core to stall its input
  task automatic test_backpressure();
    write_reg(CFG_UNIT_TCKS, 16'd1);
    write_reg(CFG_ACK_TCKS, 16'd4);
    set_traffic(90, 0, 100, 10);
    in_gaps = 1'b0;
    stall_len = 300;
    drive_ticks(80);
    in_gaps = 1'b1;
    settle();
  endtask

  // random settings per phase; one phase runs with no idling at all
  task automatic test_random_traffic();
    for (int k = 0; k < 7; k++) begin
      write_reg(CFG_DEV_ADDR,
                (k == 0) ? 16'd0 : (k == 1) ? 16'd127 : 16'($urandom_range(127)));
      write_reg(CFG_UNIT_TCKS,
                ($urandom_range(3) == 0) ? 16'($urandom_range(5, 3))
                                         : 16'($urandom_range(2)));
      write_reg(CFG_ACK_TCKS,
                (k == 5) ? 16'd255 :
                ($urandom_range(4) == 0) ? 16'd0 : 16'($urandom_range(12, 1)));
      in_gaps = (k != 3);
      out_gaps = (k != 3);
      set_traffic(85, 15, 30, 5);
      drive_ticks((k == 3) ? 150 : 35);
      settle();
    end
    in_gaps = 1'b1;
    out_gaps = 1'b1;
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = 8'd0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    in_gaps = 1'b1;
    out_gaps = 1'b1;
    stall_len = 0;
    mismatches = 0;
    ticks_sent = 0;
    transfers_done = 0;
    nacks_seen = 0;
    keys_seen = 0;
    reg_writes = 0;
    plan_word = 16'd0;
    plan_ack = 1'b1;
    plan_noise = 1'b0;
    poll_wait = 0;
    set_traffic(100, 0, 0, 0);
    model_reset();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_idle_after_reset();
    test_zero_settings();
    test_extreme_settings();
    test_requests_while_busy();
    test_midstream_config();
    test_backpressure();
    test_random_traffic();

    settle();
    $display("run covered %0d ticks, %0d transfers (%0d address nacks, %0d keys decoded)",
             ticks_sent, transfers_done, nacks_seen, keys_seen);
    $display("across %0d register writes, with stalls and a long result hold-off",
             reg_writes);
    if (mismatches == 0) begin
      $display("[i2c_keypad_reader_core] OK");
    end else begin
      $display("[i2c_keypad_reader_core] ERROR");
    end
    $finish;
  end

endmodule
